// ===== rtl/core/lcar_pkg.sv =====
// ----------------------------------------------------------------------------
// lcar_pkg
// Shared types and constants for the load cell converter reader.
// ----------------------------------------------------------------------------
package lcar_pkg;

	// Converter sample and field widths
	localparam int SAMPLE_BITS = 24;
	localparam int COUNT_W     = 7;
	localparam int GAP_W       = 20;
	localparam int SCALE_W     = 24;
	localparam int AVG_W       = 24;
	localparam int UNITS_W     = 41;
	localparam int CFG_W       = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int BITCNT_W    = 5;

	// Serial divider sizing: |diff| * 65536 fits in 40 bits
	localparam int DIV_DVD_W = 40;
	localparam int DIV_DVS_W = 24;
	localparam int FRAC_W    = 16;

	// Request opcodes
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_MEASURE = 2'd1;
	localparam logic [1:0] OP_TARE    = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

	// Per-tick status from the conversion sequencer
	typedef struct packed {
		logic sck;
		logic busy;
		logic finish;
		logic tare;
	} lcar_tick_t;

endpackage

// ===== rtl/core/lcar_div.sv =====
// ----------------------------------------------------------------------------
// lcar_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcar_div #(
	parameter int DVD_W = 40,
	parameter int DVS_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             active_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   trial_sub;
	logic             qbit;
	logic [DVS_W-1:0] rem_d;

	// One restoring step: shift in next dividend bit, try subtract
	always_comb begin
		trial     = {rem_q, quo_q[DVD_W-1]};
		trial_sub = trial - {1'b0, dvs_q};
		qbit      = (trial >= {1'b0, dvs_q});
		rem_d     = qbit ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_W'(DVD_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (active_q) begin
			quo_q <= {quo_q[DVD_W-2:0], qbit};
			rem_q <= rem_d;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/lcar_conv.sv =====
// ----------------------------------------------------------------------------
// lcar_conv
// Tick sequencer: waits for data low, clocks 24 bits into a shift register,
// gives the gain pulse, accumulates samples and counts gap ticks.
// ----------------------------------------------------------------------------
module lcar_conv import lcar_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int CNT_W       = 7,
	parameter int SUM_W       = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [1:0]         opcode,
	input  logic               dout_level,
	input  logic [COUNT_W-1:0] sample_count,
	input  logic [GAP_W-1:0]   sample_gap_ticks,
	output lcar_tick_t         tick,
	output logic [SUM_W-1:0]   sum_next,
	output logic [CNT_W-1:0]   count_next
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_WAIT = 3'd1;
	localparam logic [2:0] PH_HIGH = 3'd2;
	localparam logic [2:0] PH_LOW  = 3'd3;
	localparam logic [2:0] PH_GAIN = 3'd4;
	localparam logic [2:0] PH_GAP  = 3'd5;

	logic [2:0]             phase_q, phase_d;
	logic [BITCNT_W-1:0]    bit_q, bit_d;
	logic [SAMPLE_BITS-1:0] shift_q, shift_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [GAP_W-1:0]       gap_q, gap_d;
	logic [SUM_W-1:0]       sum_q, sum_d;
	logic                   tare_q, tare_d;

	logic [CNT_W-1:0]       eff_count;
	logic [SUM_W-1:0]       sample_ext;
	logic [SUM_W-1:0]       sum_add;
	logic [CNT_W-1:0]       cnt_inc;
	logic                   sck;
	logic                   finish;

	// Clamp the requested sample count to 1..MAX_SAMPLES
	always_comb begin
		if (sample_count == '0) begin
			eff_count = CNT_W'(1);
		end else if (32'(sample_count) > 32'(MAX_SAMPLES)) begin
			eff_count = CNT_W'(MAX_SAMPLES);
		end else begin
			eff_count = CNT_W'(sample_count);
		end
	end

	assign sample_ext = {{(SUM_W-SAMPLE_BITS){shift_q[SAMPLE_BITS-1]}}, shift_q};
	assign sum_add    = sum_q + sample_ext;
	assign cnt_inc    = cnt_q + CNT_W'(1);

	// Next-state logic for one tick
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		cnt_d   = cnt_q;
		gap_d   = gap_q;
		sum_d   = sum_q;
		tare_d  = tare_q;
		sck     = 1'b0;
		finish  = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (opcode inside {OP_MEASURE, OP_TARE}) begin
					tare_d  = (opcode == OP_TARE);
					cnt_d   = '0;
					sum_d   = '0;
					bit_d   = '0;
					shift_d = '0;
					gap_d   = '0;
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				// data low means a conversion is ready
				if (!dout_level) begin
					bit_d   = '0;
					shift_d = '0;
					sck     = 1'b1;
					phase_d = PH_HIGH;
				end
			end
			PH_HIGH: begin
				shift_d = {shift_q[SAMPLE_BITS-2:0], dout_level};
				bit_d   = bit_q + BITCNT_W'(1);
				phase_d = PH_LOW;
			end
			PH_LOW: begin
				sck     = 1'b1;
				phase_d = (bit_q < BITCNT_W'(SAMPLE_BITS)) ? PH_HIGH : PH_GAIN;
			end
			PH_GAIN: begin
				sum_d = sum_add;
				cnt_d = cnt_inc;
				if (cnt_inc >= eff_count) begin
					finish  = 1'b1;
					phase_d = PH_IDLE;
				end else if (sample_gap_ticks == '0) begin
					phase_d = PH_WAIT;
				end else begin
					gap_d   = sample_gap_ticks;
					phase_d = PH_GAP;
				end
			end
			PH_GAP: begin
				if (gap_q <= GAP_W'(1)) begin
					gap_d   = '0;
					phase_d = PH_WAIT;
				end else begin
					gap_d = gap_q - GAP_W'(1);
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			cnt_q   <= '0;
			gap_q   <= '0;
			sum_q   <= '0;
			tare_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			cnt_q   <= cnt_d;
			gap_q   <= gap_d;
			sum_q   <= sum_d;
			tare_q  <= tare_d;
		end
	end

	assign tick.sck    = sck;
	assign tick.busy   = (phase_d != PH_IDLE);
	assign tick.finish = finish;
	assign tick.tare   = tare_q;
	assign sum_next    = sum_add;
	assign count_next  = cnt_inc;

endmodule

// ===== rtl/core/load_cell_adc_reader_top.sv =====
// ----------------------------------------------------------------------------
// load_cell_adc_reader_top
// Tick-driven reader for a 24-bit load cell converter with averaging, tare
// and scaling to Q.8 units.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  -------  --------------------  ---------------------------------------------
//  in       in_valid / in_stall   opcode, dout_level
//  out      out_valid / out_stall sck_level, busy_res, result_valid,
//                                 result_kind, average_raw, units_q8
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  An ordinary tick is staged on acceptance and reaches the output register
//  from the hold state once the output is free. The tick that ends a job
//  runs the shared 40-step serial divider first: once for a tare (average
//  only), twice for a measure (average, then scaling).
//  Input is stalled from acceptance until its result is loaded; the output
//  register lets the next tick enter while a result waits downstream.
//  Reset clears the sequencers, tare offset and output valid, and sets the
//  configuration registers to defaults.
module load_cell_adc_reader_top import lcar_pkg::*; #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                opcode,
	input  logic                      dout_level,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      sck_level,
	output logic                      busy_res,
	output logic                      result_valid,
	output logic                      result_kind,
	output logic signed [AVG_W-1:0]   average_raw,
	output logic signed [UNITS_W-1:0] units_q8,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;

	localparam logic [2:0] ST_READY = 3'd0;
	localparam logic [2:0] ST_LDA   = 3'd1;
	localparam logic [2:0] ST_DIVA  = 3'd2;
	localparam logic [2:0] ST_LDU   = 3'd3;
	localparam logic [2:0] ST_DIVU  = 3'd4;
	localparam logic [2:0] ST_HOLD  = 3'd5;

	logic [2:0]               st_q;
	logic                     accept;

	logic [COUNT_W-1:0]       cfg_count_q;
	logic [GAP_W-1:0]         cfg_gap_q;
	logic [SCALE_W-1:0]       cfg_scale_q;
	logic [AVG_W-1:0]         tare_offset_q;

	lcar_tick_t               tick;
	logic [SUM_W-1:0]         sum_next;
	logic [CNT_W-1:0]         count_next;

	logic [SUM_W-1:0]         sum_s1;
	logic [CNT_W-1:0]         cnt_s1;
	logic                     neg_q;

	logic                     res_sck_q;
	logic                     res_busy_q;
	logic                     res_valid_q;
	logic                     res_kind_q;
	logic [AVG_W-1:0]         res_avg_q;
	logic [UNITS_W-1:0]       res_units_q;

	logic                     out_valid_q;
	logic                     out_sck_q;
	logic                     out_busy_q;
	logic                     out_rvalid_q;
	logic                     out_kind_q;
	logic [AVG_W-1:0]         out_avg_q;
	logic [UNITS_W-1:0]       out_units_q;

	logic                     div_start;
	logic [DIV_DVD_W-1:0]     div_dvd;
	logic [DIV_DVS_W-1:0]     div_dvs;
	logic                     div_done;
	logic [DIV_DVD_W-1:0]     div_quo;

	logic [SUM_W-1:0]         sum_mag;
	logic [AVG_W:0]           diff;
	logic [AVG_W:0]           diff_mag;
	logic [AVG_W-1:0]         avg_val;
	logic [UNITS_W-1:0]       units_val;
	logic                     out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (st_q != ST_READY);
	assign out_free = !out_valid_q || !out_stall;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q <= COUNT_W'(1);
			cfg_gap_q   <= GAP_W'(10000);
			cfg_scale_q <= SCALE_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COUNT: cfg_count_q <= cfg_data[COUNT_W-1:0];
				CFG_GAP:   cfg_gap_q   <= cfg_data[GAP_W-1:0];
				CFG_SCALE: cfg_scale_q <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Conversion sequencer
	lcar_conv #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W)
	) u_conv (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (accept),
		.opcode           (opcode),
		.dout_level       (dout_level),
		.sample_count     (cfg_count_q),
		.sample_gap_ticks (cfg_gap_q),
		.tick             (tick),
		.sum_next         (sum_next),
		.count_next       (count_next)
	);

	// Divider operand selection: average first, then scaled difference
	always_comb begin
		sum_mag  = sum_s1[SUM_W-1] ? (-sum_s1) : sum_s1;
		diff     = {res_avg_q[AVG_W-1], res_avg_q} - {tare_offset_q[AVG_W-1], tare_offset_q};
		diff_mag = diff[AVG_W] ? (-diff) : diff;
		avg_val  = neg_q ? (-div_quo[AVG_W-1:0]) : div_quo[AVG_W-1:0];
		units_val = neg_q ? (-{1'b0, div_quo}) : {1'b0, div_quo};
		div_start = 1'b0;
		div_dvd   = DIV_DVD_W'(sum_mag);
		div_dvs   = DIV_DVS_W'(cnt_s1);
		if (st_q == ST_LDA) begin
			div_start = 1'b1;
		end else if (st_q == ST_LDU) begin
			div_start = 1'b1;
			div_dvd   = {diff_mag[AVG_W-1:0], {FRAC_W{1'b0}}};
			div_dvs   = (cfg_scale_q == '0) ? DIV_DVS_W'(1) : cfg_scale_q;
		end
	end

	lcar_div #(
		.DVD_W (DIV_DVD_W),
		.DVS_W (DIV_DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Job control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_READY;
			tare_offset_q <= '0;
		end else begin
			case (st_q)
				ST_READY: begin
					if (accept) begin
						st_q <= tick.finish ? ST_LDA : ST_HOLD;
					end
				end
				ST_LDA: begin
					st_q <= ST_DIVA;
				end
				ST_DIVA: begin
					if (div_done) begin
						if (res_kind_q) begin
							tare_offset_q <= avg_val;
							st_q          <= ST_HOLD;
						end else begin
							st_q <= ST_LDU;
						end
					end
				end
				ST_LDU: begin
					st_q <= ST_DIVU;
				end
				ST_DIVU: begin
					if (div_done) begin
						st_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						st_q <= ST_READY;
					end
				end
				default: begin
					st_q <= ST_READY;
				end
			endcase
		end
	end

	// Result staging
	always_ff @(posedge clk) begin
		if (accept) begin
			res_sck_q   <= tick.sck;
			res_busy_q  <= tick.busy;
			res_valid_q <= tick.finish;
			res_kind_q  <= tick.finish && tick.tare;
			res_avg_q   <= '0;
			res_units_q <= '0;
			sum_s1      <= sum_next;
			cnt_s1      <= count_next;
		end
		if (st_q == ST_LDA) begin
			neg_q <= sum_s1[SUM_W-1];
		end else if (st_q == ST_LDU) begin
			neg_q <= diff[AVG_W];
		end
		if (st_q == ST_DIVA && div_done) begin
			res_avg_q <= avg_val;
		end
		if (st_q == ST_DIVU && div_done) begin
			res_units_q <= units_val;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_HOLD && out_free) begin
			out_sck_q    <= res_sck_q;
			out_busy_q   <= res_busy_q;
			out_rvalid_q <= res_valid_q;
			out_kind_q   <= res_kind_q;
			out_avg_q    <= res_avg_q;
			out_units_q  <= res_units_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sck_level    = out_sck_q;
	assign busy_res     = out_busy_q;
	assign result_valid = out_rvalid_q;
	assign result_kind  = out_kind_q;
	assign average_raw  = $signed(out_avg_q);
	assign units_q8     = $signed(out_units_q);

	// Checks
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_DIVA || st_q == ST_DIVU))
		else $error("divider finished outside a divide state");

	a_finish_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && tick.finish) |=> (st_q == ST_LDA))
		else $error("finishing tick did not start the average divide");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_rvalid_q) |-> !out_busy_q)
		else $error("finished job reported as still busy");

endmodule
